// ----- hw/rtl/ctfd_pkg.sv -----
`default_nettype none

package ctfd_pkg;

   // Longest token the window can hold
   localparam int TOKEN_MAX_DEF = 16;

   // Configuration widths and register indexes
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;
   localparam int LEN_W      = 5;
   localparam int TOK_W      = 2 * CSR_DATA_W;

   localparam logic [CSR_IDX_W-1:0] REG_TOKEN_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TOKEN_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TOKEN_LEN  = 2'd2;

   localparam logic [LEN_W-1:0] TOKEN_LEN_RST = 5'd11;

   // Characters that drive the comment scanner and the word test
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_NL    = 8'h0A;
   localparam logic [7:0] CHAR_USCORE = 8'h5F;

   // Per-position results of one window cell
   typedef struct packed {
      logic hit_nl;    // byte agrees with the token, word ending before the new byte
      logic hit_l;     // byte agrees with the token, word ending on the last byte
      logic bad_nl;    // leading neighbor is a word character
      logic bad_l;
      logic start_nl;  // first token character may start a word here
      logic start_l;
   } cell_flags_type;

   // Start eligibility from the comment scanner
   typedef struct packed {
      logic elig_look;  // held byte (now in window cell 0)
      logic elig_last;  // the incoming byte, valid when it is the last one
   } scan_type;

   function automatic logic is_word(input logic [7:0] c);
      logic res;
      res = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
            (c >= 8'h30 && c <= 8'h39) || (c == CHAR_USCORE);
      return res;
   endfunction

   function automatic logic [7:0] tok_byte(input logic [TOK_W-1:0] tok,
                                           input logic [3:0] j);
      logic [7:0] res;
      res = tok[{j, 3'b000} +: 8];
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ctfd_cell.sv -----
`default_nettype none

// One window position: holds a text byte and its start flag, shifts them on
module ctfd_cell #(
   parameter int IDX = 0
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       shift,
   input  wire logic                       clear,
   input  wire logic [7:0]                 byte_in,
   input  wire logic                       elig_in,
   input  wire logic [ctfd_pkg::TOK_W-1:0] token,
   input  wire logic [ctfd_pkg::LEN_W-1:0] len,
   output logic [7:0]                      byte_out,
   output logic                            elig_out,
   output ctfd_pkg::cell_flags_type        flags
);

   localparam logic [ctfd_pkg::LEN_W-1:0] POS = ctfd_pkg::LEN_W'(IDX);

   logic [7:0] byte_ff, byte_in_d;
   logic       elig_ff, elig_in_d;
   logic       elig_eff;
   logic [ctfd_pkg::LEN_W-1:0] off_nl, off_l;
   logic [ctfd_pkg::LEN_W-1:0] pos1, pos2;
   logic       word;

   // Shift register stage, cleared between texts
   always_comb begin
      byte_in_d = byte_ff;
      elig_in_d = elig_ff;
      if (clear) begin
         byte_in_d = '0;
         elig_in_d = 1'b0;
      end else if (shift) begin
         byte_in_d = byte_in;
         elig_in_d = elig_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= '0;
         elig_ff <= 1'b0;
      end else begin
         byte_ff <= byte_in_d;
         elig_ff <= elig_in_d;
      end
   end

   // The front cell's flag is classified only once its successor arrives
   assign elig_eff = (IDX == 0) ? elig_in : elig_ff;

   assign pos1   = POS + 5'd1;
   assign pos2   = POS + 5'd2;
   assign off_nl = len - 5'd1 - POS;
   assign off_l  = len - 5'd2 - POS;
   assign word   = ctfd_pkg::is_word(byte_ff);

   // Compare against the token at both alignments
   always_comb begin
      flags.hit_nl   = (POS < len) ?
                       (byte_ff == ctfd_pkg::tok_byte(token, off_nl[3:0])) : 1'b1;
      flags.hit_l    = (pos1 < len) ?
                       (byte_ff == ctfd_pkg::tok_byte(token, off_l[3:0])) : 1'b1;
      flags.bad_nl   = (len == POS) && word;
      flags.bad_l    = (len == pos1) && word;
      flags.start_nl = (len == pos1) && elig_eff;
      flags.start_l  = (len == pos2) && elig_eff;
   end

   assign byte_out = byte_ff;
   assign elig_out = elig_eff;

endmodule

`default_nettype wire

// ----- hw/rtl/ctfd_scan.sv -----
`default_nettype none

// Comment tracker: one byte of lookahead decides openers and closers
module ctfd_scan (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        fire,
   input  wire logic        last,
   input  wire logic [7:0]  text_byte,
   output ctfd_pkg::scan_type scan
);

   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_LINE   = 2'd1;
   localparam logic [1:0] MODE_BLOCK  = 2'd2;

   typedef struct packed {
      logic       elig;
      logic       eat;
      logic [1:0] mode;
   } cls_type;

   function automatic cls_type classify(input logic [1:0] mode,
                                        input logic [7:0] c,
                                        input logic [7:0] nxt,
                                        input logic       has_next);
      cls_type res;
      res.elig = 1'b0;
      res.eat  = 1'b0;
      res.mode = mode;
      case (mode)
         MODE_LINE: begin
            if (c == ctfd_pkg::CHAR_NL) begin
               res.mode = MODE_NORMAL;
               res.elig = 1'b1;
            end
         end
         MODE_BLOCK: begin
            if (c == ctfd_pkg::CHAR_STAR && has_next && nxt == ctfd_pkg::CHAR_SLASH) begin
               res.eat  = 1'b1;
               res.mode = MODE_NORMAL;
            end
         end
         MODE_NORMAL: begin
            if (c == ctfd_pkg::CHAR_SLASH && has_next &&
                (nxt == ctfd_pkg::CHAR_SLASH || nxt == ctfd_pkg::CHAR_STAR)) begin
               res.eat  = 1'b1;
               res.mode = (nxt == ctfd_pkg::CHAR_SLASH) ? MODE_LINE : MODE_BLOCK;
            end else begin
               res.elig = 1'b1;
            end
         end
         default: begin
            res.mode = MODE_NORMAL;
         end
      endcase
      return res;
   endfunction

   logic [1:0] mode_ff, mode_in;
   logic       look_valid_ff, look_valid_in;
   logic [7:0] look_byte_ff, look_byte_in;
   cls_type    cls_look, cls_cur;
   logic       pending;

   // Held byte is classified against the new one; on the last byte the new
   // one is classified too, with nothing after it
   always_comb begin
      cls_look = classify(mode_ff, look_byte_ff, text_byte, 1'b1);
      if (!look_valid_ff) begin
         cls_look.elig = 1'b0;
         cls_look.eat  = 1'b0;
         cls_look.mode = mode_ff;
      end
      pending = !(look_valid_ff && cls_look.eat);
      cls_cur = classify(cls_look.mode, text_byte, 8'h00, 1'b0);
      scan.elig_look = cls_look.elig;
      scan.elig_last = pending && cls_cur.elig;
   end

   // Next state
   always_comb begin
      mode_in       = mode_ff;
      look_valid_in = look_valid_ff;
      look_byte_in  = look_byte_ff;
      if (fire) begin
         if (last) begin
            mode_in       = MODE_NORMAL;
            look_valid_in = 1'b0;
         end else begin
            mode_in       = cls_look.mode;
            look_valid_in = pending;
            look_byte_in  = text_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_NORMAL;
         look_valid_ff <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         look_valid_ff <= look_valid_in;
      end
      look_byte_ff <= look_byte_in;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/comment_aware_token_finder.sv -----
// comment_aware_token_finder
// Searches C source text for a configured token (1 to 16 characters) that
// stands as a whole word outside // and /* */ comments.
// Channels:
//   req_*  text in, one byte per request; req_tlast marks the last byte.
//   rsp_*  one result per text, rsp_tdata[0] = found, sent after the last byte.
//   csr_*  register writes: 0 token chars 0..7, 1 token chars 8..15,
//          2 token length. Write only while no text is in flight.
// Throughput: one byte per cycle while no result is stalled; a new text may follow the
// last byte of the previous one directly. The window is a shift row of
// TOKEN_MAX+1 cells that all compare in parallel in the accepting cycle.
// Latency: the result is registered and valid the cycle after the last byte.
// Stall: while a result waits and rsp_tready is low, req_tready is low.
// Reset: clears the stream state and the result valid flag, token registers
// return to zero and the length to 11. No clearing pass is needed.
`default_nettype none

module comment_aware_token_finder #(
   parameter int TOKEN_MAX = ctfd_pkg::TOKEN_MAX_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request: text_byte
   input  wire logic [7:0]                      req_tdata,
   input  wire logic                            req_tlast,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // response: found, zero-filled above bit 0
   output logic [7:0]                           rsp_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [ctfd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ctfd_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int WIN = TOKEN_MAX + 1;
   localparam logic [ctfd_pkg::LEN_W-1:0] LEN_MAX = ctfd_pkg::LEN_W'(TOKEN_MAX);
   localparam logic [ctfd_pkg::LEN_W-1:0] CNT_MAX = '1;

   // Configuration registers
   logic [ctfd_pkg::CSR_DATA_W-1:0] tok_low_ff, tok_high_ff;
   logic [ctfd_pkg::LEN_W-1:0]      tok_len_ff;
   logic [ctfd_pkg::TOK_W-1:0]      token;
   logic [ctfd_pkg::LEN_W-1:0]      len;
   logic [ctfd_pkg::LEN_W-1:0]      len_m1;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_low_ff  <= '0;
         tok_high_ff <= '0;
         tok_len_ff  <= ctfd_pkg::TOKEN_LEN_RST;
      end else if (csr_valid) begin
         case (csr_index)
            ctfd_pkg::REG_TOKEN_LOW:  tok_low_ff  <= csr_data;
            ctfd_pkg::REG_TOKEN_HIGH: tok_high_ff <= csr_data;
            ctfd_pkg::REG_TOKEN_LEN:  tok_len_ff  <= csr_data[ctfd_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

   assign token = {tok_high_ff, tok_low_ff};

   // Clamp the length into 1..TOKEN_MAX
   always_comb begin
      if (tok_len_ff == '0) begin
         len = 5'd1;
      end else if (tok_len_ff > LEN_MAX) begin
         len = LEN_MAX;
      end else begin
         len = tok_len_ff;
      end
   end
   assign len_m1 = len - 5'd1;

   // Handshake
   logic rsp_valid_ff, rsp_valid_in;
   logic found_ff, found_in;
   logic req_fire, last_fire;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign last_fire  = req_fire && req_tlast;

   // Comment tracking
   ctfd_pkg::scan_type scan;

   ctfd_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .fire      (req_fire),
      .last      (req_tlast),
      .text_byte (req_tdata),
      .scan      (scan)
   );

   // Window row
   logic [7:0]               byte_chain [WIN];
   logic                     elig_chain [WIN];
   ctfd_pkg::cell_flags_type flags      [WIN];

   for (genvar k = 0; k < WIN; k++) begin : g_cell
      logic [7:0] byte_src;
      logic       elig_src;
      if (k == 0) begin : g_head
         assign byte_src = req_tdata;
         assign elig_src = scan.elig_look;
      end else begin : g_body
         assign byte_src = byte_chain[k-1];
         assign elig_src = elig_chain[k-1];
      end
      ctfd_cell #(.IDX(k)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift    (req_fire),
         .clear    (last_fire),
         .byte_in  (byte_src),
         .elig_in  (elig_src),
         .token    (token),
         .len      (len),
         .byte_out (byte_chain[k]),
         .elig_out (elig_chain[k]),
         .flags    (flags[k])
      );
   end

   // Gather the cell flags
   logic all_hit_nl, all_hit_l, any_bad_nl, any_bad_l, any_start_nl, any_start_l;

   always_comb begin
      all_hit_nl   = 1'b1;
      all_hit_l    = 1'b1;
      any_bad_nl   = 1'b0;
      any_bad_l    = 1'b0;
      any_start_nl = 1'b0;
      any_start_l  = 1'b0;
      for (int k = 0; k < WIN; k++) begin
         all_hit_nl   = all_hit_nl & flags[k].hit_nl;
         all_hit_l    = all_hit_l & flags[k].hit_l;
         any_bad_nl   = any_bad_nl | flags[k].bad_nl;
         any_bad_l    = any_bad_l | flags[k].bad_l;
         any_start_nl = any_start_nl | flags[k].start_nl;
         any_start_l  = any_start_l | flags[k].start_l;
      end
   end

   // Match decision
   logic [ctfd_pkg::LEN_W-1:0] chars_ff, chars_in;
   logic match_ff, match_in;
   logic match_nl, match_l, start_l, found;

   // word ending just before the new byte, and word ending on the last byte
   assign match_nl = all_hit_nl && !any_bad_nl && any_start_nl &&
                     !ctfd_pkg::is_word(req_tdata) && (chars_ff >= len);
   assign start_l  = (len == 5'd1) ? scan.elig_last : any_start_l;
   assign match_l  = all_hit_l && !any_bad_l && start_l && (chars_ff >= len_m1) &&
                     (req_tdata == ctfd_pkg::tok_byte(token, len_m1[3:0]));
   assign found    = match_ff || match_nl || match_l;

   always_comb begin
      chars_in     = chars_ff;
      match_in     = match_ff;
      rsp_valid_in = rsp_valid_ff;
      found_in     = found_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_fire) begin
         if (req_tlast) begin
            chars_in     = '0;
            match_in     = 1'b0;
            rsp_valid_in = 1'b1;
            found_in     = found;
         end else begin
            chars_in = (chars_ff != CNT_MAX) ? chars_ff + 5'd1 : chars_ff;
            match_in = match_ff || match_nl;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chars_ff     <= '0;
         match_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         chars_ff     <= chars_in;
         match_ff     <= match_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      found_ff <= found_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0000000, found_ff};

   // Checks
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      last_fire |=> rsp_valid_ff && chars_ff == '0 && !match_ff)
      else $error("stream state not cleared after last byte");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      req_fire && !req_tlast && chars_ff != CNT_MAX |=> chars_ff == $past(chars_ff) + 5'd1)
      else $error("byte count did not advance");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("request taken while result stalled");

   a_sticky: assert property (@(posedge clock) disable iff (reset)
      match_ff && req_fire && req_tlast |=> found_ff)
      else $error("earlier match lost");

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
module tb_top;

   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 8;
   localparam int STALL_LIMIT  = 1000;
   localparam int RANDOM_BYTES = 1300;
   localparam int TAIL_BYTES   = 150;
   localparam int HIST_LEN     = ctfd_pkg::TOKEN_MAX_DEF + 1;
   localparam int SEQ_W        = 8 * (ctfd_pkg::TOKEN_MAX_DEF + 2);
   localparam int COUNT_SAT    = 31;

   typedef enum logic [1:0] {SCAN_TEXT, SCAN_LINE, SCAN_BLOCK} scan_mode_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic [7:0]                      req_tdata;
   logic                            req_tlast;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [7:0]                      rsp_tdata;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [ctfd_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [ctfd_pkg::CSR_DATA_W-1:0] csr_data;

   // Test state
   bit                    quiet;
   int unsigned           bytes_sent;
   int unsigned           mismatches;
   int unsigned           rsp_stall_left;
   int unsigned           idle_cycles;
   logic [7:0]            text_q[$];
   bit                    expected_found[$];

   // Shadow of the token registers
   logic [ctfd_pkg::TOK_W-1:0] tok_bits;
   logic [ctfd_pkg::LEN_W-1:0] tok_len_raw;

   // Shadow of the stream scanner
   scan_mode_type         scan_mode;
   logic                  look_valid;
   logic [7:0]            look_char;
   logic [7:0]            hist[HIST_LEN];
   logic [HIST_LEN-1:0]   start_ok;
   int unsigned           seen;
   bit                    hit;

   comment_aware_token_finder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // ---------------------------------------------------------------
   // Scanner model
   // ---------------------------------------------------------------
   function automatic void add_char(input logic [7:0] c);
      text_q.insert(text_q.size(), c);
   endfunction

   function automatic void clear_stream();
      scan_mode  = SCAN_TEXT;
      look_valid = 1'b0;
      look_char  = 8'h00;
      foreach (hist[k]) hist[k] = 8'h00;
      start_ok   = '0;
      seen       = 0;
      hit        = 1'b0;
   endfunction

   function automatic bit is_ident_char(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
             (c >= "0" && c <= "9") || c == ctfd_pkg::CHAR_USCORE;
   endfunction

   // out-of-range lengths clamp to 1..TOKEN_MAX
   function automatic int unsigned clamped_len();
      int unsigned n;
      n = 32'(tok_len_raw);
      if (n == 0) n = 1;
      if (n > ctfd_pkg::TOKEN_MAX_DEF) n = ctfd_pkg::TOKEN_MAX_DEF;
      return n;
   endfunction

   // Classifies one held char, advancing the comment mode; 1 = word may start
   function automatic bit classify_char(input logic [7:0] c, input logic [7:0] nxt,
                                        input bit has_nxt, output bit eat);
      bit ok;
      eat = 1'b0;
      ok  = 1'b0;
      case (scan_mode)
         SCAN_LINE: begin
            if (c == ctfd_pkg::CHAR_NL) begin
               scan_mode = SCAN_TEXT;
               ok = 1'b1;
            end
         end
         SCAN_BLOCK: begin
            if (c == ctfd_pkg::CHAR_STAR && has_nxt && nxt == ctfd_pkg::CHAR_SLASH) begin
               eat = 1'b1;
               scan_mode = SCAN_TEXT;
            end
         end
         default: begin
            if (c == ctfd_pkg::CHAR_SLASH && has_nxt &&
                (nxt == ctfd_pkg::CHAR_SLASH || nxt == ctfd_pkg::CHAR_STAR)) begin
               eat = 1'b1;
               scan_mode = (nxt == ctfd_pkg::CHAR_SLASH) ? SCAN_LINE : SCAN_BLOCK;
            end else begin
               ok = 1'b1;
            end
         end
      endcase
      return ok;
   endfunction

   // seq byte 0 = leading neighbor, 1..n = candidate, n+1 = trailing neighbor
   function automatic bit token_at(input logic [SEQ_W-1:0] seq, input int unsigned n,
                                   input bit at_end);
      int unsigned j;
      bit ok;
      ok = !is_ident_char(seq[7:0]);
      for (j = 0; j < n; j++)
         if (seq[8*(j+1) +: 8] != tok_bits[8*j +: 8]) ok = 1'b0;
      if (!at_end && is_ident_char(seq[8*(n+1) +: 8])) ok = 1'b0;
      return ok;
   endfunction

   // Advances the model by one text byte; queues found on the last byte
   function automatic void scan_text_byte(input logic [7:0] b, input bit is_last);
      int unsigned n;
      int unsigned p;
      int unsigned j;
      int k;
      logic [HIST_LEN-1:0] el;
      logic [SEQ_W-1:0] seq;
      bit keep;
      bit eat;
      n    = clamped_len();
      p    = seen;
      el   = start_ok << 1;
      keep = 1'b1;
      if (look_valid) begin
         el[1] = el[1] | classify_char(look_char, b, 1'b1, eat);
         if (eat) keep = 1'b0;
      end
      // word ending before this byte
      if (p >= n && el[n]) begin
         seq = '0;
         seq[7:0] = hist[n];
         for (j = 0; j < n; j++) seq[8*(j+1) +: 8] = hist[n-1-j];
         seq[8*(n+1) +: 8] = b;
         if (token_at(seq, n, 1'b0)) hit = 1'b1;
      end
      look_valid = keep;
      look_char  = b;
      if (is_last) begin
         if (keep) el[0] = el[0] | classify_char(b, 8'h00, 1'b0, eat);
         // word ending on the last byte
         if (p + 1 >= n && el[n-1]) begin
            seq = '0;
            seq[7:0] = hist[n-1];
            for (j = 0; j < n; j++) begin
               if (j == n - 1) seq[8*(j+1) +: 8] = b;
               else seq[8*(j+1) +: 8] = hist[n-2-j];
            end
            if (token_at(seq, n, 1'b1)) hit = 1'b1;
         end
         expected_found.insert(expected_found.size(), hit);
         clear_stream();
      end else begin
         for (k = HIST_LEN - 1; k > 0; k--) hist[k] = hist[k-1];
         hist[0]  = b;
         start_ok = el;
         seen     = (p < COUNT_SAT) ? p + 1 : COUNT_SAT;
      end
   endfunction

   // ---------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b, input bit is_last);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_tdata  = b;
      req_tlast  = is_last;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      scan_text_byte(b, is_last);
      bytes_sent++;
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic send_text();
      int unsigned i;
      for (i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
   endtask

   task automatic text_from(input string s);
      int i;
      text_q.delete();
      for (i = 0; i < s.len(); i++) add_char(s[i]);
   endtask

   task automatic write_reg(input logic [ctfd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [ctfd_pkg::CSR_DATA_W-1:0] d);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = d;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         ctfd_pkg::REG_TOKEN_LOW:  tok_bits[63:0]   = d;
         ctfd_pkg::REG_TOKEN_HIGH: tok_bits[127:64] = d;
         ctfd_pkg::REG_TOKEN_LEN:  tok_len_raw      = d[ctfd_pkg::LEN_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // hold requests until every result is back, then let the pipe drain
   task automatic wait_idle();
      while (expected_found.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic load_token(input logic [ctfd_pkg::TOK_W-1:0] t,
                             input logic [ctfd_pkg::LEN_W-1:0] raw);
      logic [ctfd_pkg::CSR_DATA_W-1:0] d;
      wait_idle();
      write_reg(ctfd_pkg::REG_TOKEN_LOW, t[63:0]);
      write_reg(ctfd_pkg::REG_TOKEN_HIGH, t[127:64]);
      // junk above the length field must be dropped
      d = {$urandom, $urandom};
      d[ctfd_pkg::LEN_W-1:0] = raw;
      write_reg(ctfd_pkg::REG_TOKEN_LEN, d);
   endtask

   // ---------------------------------------------------------------
   // Text generation
   // ---------------------------------------------------------------
   function automatic logic [7:0] rand_ident_char();
      int unsigned r;
      r = $urandom_range(0, 62);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      if (r < 62) return 8'("0" + r - 52);
      return ctfd_pkg::CHAR_USCORE;
   endfunction

   function automatic logic [7:0] rand_separator();
      logic [7:0] c;
      case ($urandom_range(0, 5))
         0: c = " ";
         1: c = ctfd_pkg::CHAR_NL;
         2: c = "\t";
         3: c = "(";
         4: c = ";";
         default: c = ".";
      endcase
      return c;
   endfunction

   function automatic logic [ctfd_pkg::TOK_W-1:0] rand_token();
      logic [ctfd_pkg::TOK_W-1:0] t;
      int k;
      for (k = 0; k < ctfd_pkg::TOKEN_MAX_DEF; k++) begin
         if ($urandom_range(0, 9) == 0) t[8*k +: 8] = 8'($urandom_range(0, 255));
         else t[8*k +: 8] = rand_ident_char();
      end
      return t;
   endfunction

   // Token copies and near misses among word chars, separators and comment marks
   function automatic void build_text(input int unsigned pieces);
      int unsigned n;
      int unsigned k;
      int unsigned m;
      n = clamped_len();
      text_q.delete();
      repeat (pieces) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: begin
               for (k = 0; k < n; k++) add_char(tok_bits[8*k +: 8]);
            end
            5: begin
               m = $urandom_range(0, n - 1);
               for (k = 0; k < n; k++)
                  if (k == m) add_char(8'($urandom_range(0, 255)));
                  else add_char(tok_bits[8*k +: 8]);
            end
            6: begin
               m = $urandom_range(1, n);
               for (k = 0; k < m; k++) add_char(tok_bits[8*k +: 8]);
            end
            7, 8: repeat ($urandom_range(1, 3)) add_char(rand_ident_char());
            9, 10, 11: add_char(rand_separator());
            12: begin
               add_char(ctfd_pkg::CHAR_SLASH);
               add_char(ctfd_pkg::CHAR_SLASH);
            end
            13: begin
               add_char(ctfd_pkg::CHAR_SLASH);
               add_char(ctfd_pkg::CHAR_STAR);
            end
            14: begin
               add_char(ctfd_pkg::CHAR_STAR);
               add_char(ctfd_pkg::CHAR_SLASH);
            end
            15: add_char(ctfd_pkg::CHAR_SLASH);
            16: add_char(ctfd_pkg::CHAR_STAR);
            17: add_char(8'($urandom_range(0, 255)));
            18: add_char(8'h00);
            default: add_char(ctfd_pkg::CHAR_NL);
         endcase
      end
   endfunction

   task automatic random_texts(input int unsigned count);
      repeat (count) begin
         if ($urandom_range(0, 9) == 0) build_text($urandom_range(15, 25));
         else build_text($urandom_range(1, 10));
         send_text();
      end
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // Reset token is eleven zero chars
   task automatic test_reset_defaults();
      text_q.delete();
      repeat (11) add_char(8'h00);
      send_text();
   endtask

   task automatic test_directed_cases();
      logic [ctfd_pkg::TOK_W-1:0] t;
      t = rand_token();
      t[7:0] = "x";
      load_token(t, 5'd1);
      text_from("x");         // both neighbors are text boundaries
      send_text();
      text_from("//x\nx");    // newline closes the line comment
      send_text();
      text_from("/*/x");      // slash right after the opener does not close
      send_text();
      text_from("/**/x");
      send_text();
      text_from("x/");        // trailing slash is plain text
      send_text();
      text_from("_x");
      send_text();
      text_from("x9");
      send_text();
      // high bytes and zero never count as word chars
      text_q.delete();
      add_char(8'hFF);
      add_char("x");
      add_char(8'h00);
      send_text();
      // zero length acts as one
      load_token(t, 5'd0);
      text_from("x");
      send_text();
      // all-ones token, oversized length clamps to the max
      load_token('1, 5'd31);
      text_q.delete();
      repeat (ctfd_pkg::TOKEN_MAX_DEF) add_char(8'hFF);
      send_text();
   endtask

   task automatic test_random_texts();
      int unsigned phase;
      logic [ctfd_pkg::TOK_W-1:0] t;
      logic [ctfd_pkg::LEN_W-1:0] raw;
      phase = 0;
      while (bytes_sent < RANDOM_BYTES) begin
         t = rand_token();
         if ($urandom_range(0, 4) == 0) raw = 5'($urandom_range(17, 31));
         else raw = 5'($urandom_range(1, ctfd_pkg::TOKEN_MAX_DEF));
         case (phase)
            0: raw = 5'd0;
            1: raw = 5'd16;
            2: begin
               t[63:0] = '0;
               raw = 5'd3;
            end
            3: raw = 5'd1;
            default: ;
         endcase
         load_token(t, raw);
         random_texts($urandom_range(8, 20));
         phase++;
      end
   endtask

   task automatic test_no_idle_tail();
      int unsigned stop_at;
      quiet = 1'b1;
      load_token(rand_token(), 5'($urandom_range(1, ctfd_pkg::TOKEN_MAX_DEF)));
      stop_at = bytes_sent + TAIL_BYTES;
      while (bytes_sent < stop_at) random_texts(1);
   endtask

   // ---------------------------------------------------------------
   // Result side
   // ---------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("mismatch: %s got %0h want %0h", what, got, want);
      mismatches++;
   endtask

   // Random backpressure on the result channel
   initial begin
      rsp_tready     = 1'b1;
      rsp_stall_left = 0;
      forever begin
         @(negedge clock);
         if (rsp_stall_left > 0) begin
            rsp_tready = 1'b0;
            rsp_stall_left--;
         end else begin
            rsp_tready = 1'b1;
            if (!quiet && $urandom_range(0, 6) == 0) rsp_stall_left = $urandom_range(1, 3);
         end
      end
   end

   // Compare each result with the oldest expected one
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_found.size() == 0) begin
            report_mismatch("unexpected result", rsp_tdata, 8'h00);
         end else begin
            if (rsp_tdata[0] !== expected_found[0])
               report_mismatch("found", {7'b0, rsp_tdata[0]}, {7'b0, expected_found[0]});
            if (rsp_tdata[7:1] !== 7'b0)
               report_mismatch("pad bits", {1'b0, rsp_tdata[7:1]}, 8'h00);
            void'(expected_found.pop_front());
         end
      end
   end

   // Watchdog: too long without any handshake
   initial begin
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("[comment_aware_token_finder] ERROR");
      $finish;
   end

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      reset      = 1'b1;
      req_tdata  = 8'h00;
      req_tlast  = 1'b0;
      req_tvalid = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = ctfd_pkg::REG_TOKEN_LOW;
      csr_data   = '0;
      quiet      = 1'b0;
      bytes_sent = 0;
      mismatches = 0;
      tok_bits    = '0;
      tok_len_raw = ctfd_pkg::TOKEN_LEN_RST;
      clear_stream();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_directed_cases();
      test_random_texts();
      test_no_idle_tail();

      while (expected_found.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      if (mismatches == 0) begin
         $display("[comment_aware_token_finder] OK");
      end else begin
         $display("[comment_aware_token_finder] ERROR");
      end
      $finish;
   end

endmodule
